// ===== rtl/core/prewitt_edge_magnitude_unit_macros.svh =====
// ----------------------------------------------------------------------------
// prewitt edge magnitude unit: assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PREWITT_EDGE_MAGNITUDE_UNIT_MACROS_SVH
`define PREWITT_EDGE_MAGNITUDE_UNIT_MACROS_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define PEM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define PEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// shared types and constants of the prewitt edge magnitude unit
// ----------------------------------------------------------------------------
package pem_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W    = 8;
  localparam int DIFF_W   = 11;   // signed gradient, |value| <= 765
  localparam int SQ_W     = 20;   // one square, <= 585225
  localparam int SUM_W    = 21;   // sum of two squares
  localparam int ROOT_IN_W = 16;  // root operand below saturation
  localparam int ROW_W    = 16;
  localparam int CFG_W    = 16;
  localparam int WCFG_W   = 12;

  localparam logic [PIX_W-1:0]  SAT_LIMIT  = 8'hFF;
  localparam logic [WCFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [ROW_W-1:0]  HEIGHT_RST = 16'd480;
  localparam int                MIN_DIM    = 3;

  // register indexes of the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DONE
  } pem_state_t;

  typedef struct packed {
    logic take;       // capture pixel, read line buffers
    logic calc;       // gradients, window shift, line writes, counters
    logic square;     // register both squares
    logic sum;        // add squares, load root unit
    logic root_step;  // one digit of the root
    logic load_out;   // move result into output register
  } pem_cmd_t;

  typedef struct packed {
    logic interior;   // current pixel closes an interior window
    logic root_last;  // root unit on its final digit
    logic out_busy;   // output register full and not taken this cycle
  } pem_sts_t;

endpackage

// ===== rtl/core/pem_root.sv =====
// ----------------------------------------------------------------------------
// pem_root
// digit recurrence integer square root, two operand bits per step
// ----------------------------------------------------------------------------
module pem_root
  import pem_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  logic [ROOT_IN_W-1:0] value,
  input  logic                 step,
  output logic [PIX_W-1:0]     root,
  output logic                 last
);

  logic [ROOT_IN_W-1:0] val_r, val_nxt;
  logic [PIX_W:0]       rem_r, rem_nxt;
  logic [PIX_W-1:0]     root_r, root_nxt;
  logic [2:0]           cnt_r, cnt_nxt;
  logic [PIX_W+2:0]     rem_sh;
  logic [PIX_W+2:0]     trial;
  logic [PIX_W+2:0]     diff;
  logic                 ge;

  always_comb begin
    rem_sh   = {rem_r, val_r[ROOT_IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    diff     = rem_sh - trial;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
    end else if (step) begin
      val_nxt  = {val_r[ROOT_IN_W-3:0], 2'b00};
      rem_nxt  = ge ? diff[PIX_W:0] : rem_sh[PIX_W:0];
      root_nxt = {root_r[PIX_W-2:0], ge};
      cnt_nxt  = cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign last = (cnt_r == 3'd7);

endmodule

// ===== rtl/core/pem_ctrl.sv =====
// ----------------------------------------------------------------------------
// pem_ctrl
// sequencer: one item at a time through gradient, square, sum and root steps
// ----------------------------------------------------------------------------
module pem_ctrl
  import pem_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pem_sts_t   sts,
  output pem_cmd_t   cmd
);

  pem_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.interior ? ST_SQUARE : ST_IDLE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pem_datapath.sv =====
// ----------------------------------------------------------------------------
// pem_datapath
// line buffers, 3x3 window, gradients, squares, root and output register
// ----------------------------------------------------------------------------
module pem_datapath
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PIX_W-1:0]  in_pixel,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  pem_cmd_t          cmd,
  output pem_sts_t          sts,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [PIX_W-1:0]  out_mag,
  output logic              out_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > WCFG_W) ? CW + 1 : WCFG_W;

  // configuration
  logic [WCFG_W-1:0] width_r;
  logic [ROW_W-1:0]  height_r;

  // position of the arriving pixel
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [PIX_W-1:0] top_r, mid_r, pix_r;
  logic [PIX_W-1:0] win_r [6];

  logic signed [DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic signed [2*DIFF_W-1:0] sqx_full, sqy_full;
  logic [SUM_W-1:0]         sum;
  logic                     sat_r, last_r;
  logic                     out_valid_r;
  logic [PIX_W-1:0]         out_mag_r;
  logic                     out_last_r;

  logic [WW-1:0]    w_ext, w_eff;
  logic [CW-1:0]    last_col;
  logic [ROW_W-1:0] last_row;
  logic             col_end, row_end;
  logic [PIX_W+1:0] right_s, left_s, bottom_s, top_s;
  logic [PIX_W-1:0] root;
  logic             root_last;

  // effective frame size
  always_comb begin
    w_ext = WW'(width_r);
    if (w_ext < WW'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_col = CW'(w_eff - WW'(1));
    last_row = (height_r < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM - 1) : height_r - ROW_W'(1);
    col_end  = (col_r >= last_col);
    row_end  = (row_r >= last_row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WCFG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // line buffers: read on take, written back on calc in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      top_r <= upper_mem[col_r];
      mid_r <= middle_mem[col_r];
      pix_r <= in_pixel;
    end
    if (cmd.calc) begin
      upper_mem[col_r]  <= mid_r;
      middle_mem[col_r] <= pix_r;
    end
  end

  // column and row sums of the window, columns c-2, c-1, c
  always_comb begin
    right_s  = {2'b00, top_r} + {2'b00, mid_r} + {2'b00, pix_r};
    left_s   = {2'b00, win_r[0]} + {2'b00, win_r[1]} + {2'b00, win_r[2]};
    bottom_s = {2'b00, win_r[2]} + {2'b00, win_r[5]} + {2'b00, pix_r};
    top_s    = {2'b00, win_r[0]} + {2'b00, win_r[3]} + {2'b00, top_r};
    dx_nxt   = DIFF_W'(signed'({1'b0, right_s})) - DIFF_W'(signed'({1'b0, left_s}));
    dy_nxt   = DIFF_W'(signed'({1'b0, bottom_s})) - DIFF_W'(signed'({1'b0, top_s}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.calc) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_r;
      win_r[4] <= mid_r;
      win_r[5] <= pix_r;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;
  assign sum      = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      last_r <= row_end && col_end;
    end
    if (cmd.square) begin
      sqx_r <= sqx_full[SQ_W-1:0];
      sqy_r <= sqy_full[SQ_W-1:0];
    end
    if (cmd.sum) begin
      sat_r <= |sum[SUM_W-1:ROOT_IN_W];
    end
  end

  pem_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (cmd.sum),
    .value (sum[ROOT_IN_W-1:0]),
    .step  (cmd.root_step),
    .root  (root),
    .last  (root_last)
  );

  // output register, parts the sequencer from the consumer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_mag_r  <= sat_r ? SAT_LIMIT : root;
      out_last_r <= last_r;
    end
  end

  assign sts.interior  = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));
  assign sts.root_last = root_last;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_mag   = out_mag_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/core/prewitt_edge_magnitude_unit.sv =====
// ----------------------------------------------------------------------------
// prewitt_edge_magnitude_unit
// 3x3 prewitt gradient magnitude over a raster pixel stream
// ----------------------------------------------------------------------------
// Takes 8-bit grayscale pixels in raster order and returns, for each interior
// pixel only, min(255, floor(sqrt(dx*dx + dy*dy))), with dx the right column
// minus the left column and dy the bottom row minus the top row of its 3x3
// neighbourhood. Results leave in raster order; out_tlast marks the last
// interior pixel of the frame. Border pixels give no item. One item is in
// work at a time: a border pixel passes capture and gradient before the next
// in_tready, an interior pixel capture, gradient, square, sum, 8 root digits
// at two operand bits each and hand-over, longer only while the output
// register holds an untaken result; the 8-step root unit is the longest part.
// A new item is taken while a finished result waits in the output register.
// Line buffers need no clearing after reset; a frame's first two rows only
// write them. Width outside 3..MAX_WIDTH is clamped, height below 3 is taken
// as 3. Write configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "prewitt_edge_magnitude_unit_macros.svh"

module prewitt_edge_magnitude_unit
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF   // depth of each line buffer
) (
  input  logic              clk,
  input  logic              rst_n,
  // pixel input
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] pixel
  // magnitude output
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,   // [7:0] magnitude
  output logic              out_tlast,   // last interior pixel of the frame
  // configuration writes
  input  logic              cfg_we,
  input  logic              cfg_index,   // 0 image_width, 1 image_height
  input  logic [CFG_W-1:0]  cfg_wdata
);

  pem_cmd_t cmd;
  pem_sts_t sts;

  // sequencer
  pem_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // line buffers, window, arithmetic and output register
  pem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_mag   (out_tdata),
    .out_last  (out_tlast)
  );

  // one item in work at a time: acceptance closes the input side
  `PEM_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "item taken while busy")

  // a result never overwrites one still waiting to be taken
  `PEM_ASSERT_SAME(a_no_overwrite, cmd.load_out, !out_tvalid || out_tready, "result overwritten")

  // a result appears only at the end of an item's work, never while idle
  `PEM_ASSERT_SAME(a_rise_busy, $rose(out_tvalid), !$past(in_tready), "result without item")

endmodule

// ===== bench/prewitt_result_checker.sv =====
// ----------------------------------------------------------------------------
// prewitt_result_checker
// watches the pixel, magnitude and register ports of the edge magnitude unit,
// predicts every magnitude item from the accepted pixels and compares the
// items that leave the block against the predictions, oldest first
// ----------------------------------------------------------------------------
module prewitt_result_checker
  import pem_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,     // [7:0] pixel
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [7:0]       out_tdata,    // [7:0] magnitude
  input  logic             out_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               outstanding,
  output int               mismatches,
  output int               magnitudes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       frame_last;
  } mag_item_t;

  mag_item_t   expected_mags[$];

  logic [11:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  upper_row [MAX_WIDTH];
  logic [7:0]  middle_row [MAX_WIDTH];
  // window columns: index 0 is two columns back, index 1 one column back
  logic [7:0]  win_top [2];
  logic [7:0]  win_mid [2];
  logic [7:0]  win_bot [2];
  int unsigned col_pos;
  int unsigned row_pos;
  int          error_total;
  int          checked_total;

  function automatic logic [7:0] magnitude_of(input int dx, input int dy);
    int unsigned sum_sq;
    int unsigned root;
    int unsigned trial;
    sum_sq = dx * dx + dy * dy;
    if (sum_sq >= 32'd65536) return SAT_LIMIT;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    return root[7:0];
  endfunction

  task automatic predict_pixel(input logic [7:0] pix);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned slot;
    logic [7:0]  top;
    logic [7:0]  mid;
    int          dx;
    int          dy;
    mag_item_t   item;
    w_eff = width_reg;
    if (w_eff < MIN_DIM) w_eff = MIN_DIM;
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    slot  = col_pos % MAX_WIDTH;
    top   = upper_row[slot];
    mid   = middle_row[slot];

    if (row_pos >= 2 && col_pos >= 2) begin
      dx = (int'(top) - int'(win_top[0])) + (int'(mid) - int'(win_mid[0]))
         + (int'(pix) - int'(win_bot[0]));
      dy = (int'(win_bot[0]) - int'(win_top[0])) + (int'(win_bot[1]) - int'(win_top[1]))
         + (int'(pix) - int'(top));
      item.magnitude  = magnitude_of(dx, dy);
      item.frame_last = (row_pos >= h_eff - 1) && (col_pos >= w_eff - 1);
      expected_mags.push_back(item);
    end

    win_top[0] = win_top[1];
    win_mid[0] = win_mid[1];
    win_bot[0] = win_bot[1];
    win_top[1] = top;
    win_mid[1] = mid;
    win_bot[1] = pix;
    upper_row[slot]  = mid;
    middle_row[slot] = pix;

    if (col_pos >= w_eff - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h_eff - 1) ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = (col_pos + 1) & 32'h7FF;
    end
  endtask

  task automatic check_magnitude(input logic [7:0] mag, input logic last);
    mag_item_t item;
    if (expected_mags.size() == 0) begin
      $display("%0t ns: magnitude item with nothing expected, got magnitude %0d last %0b",
               $time, mag, last);
      error_total++;
    end else begin
      item = expected_mags.pop_front();
      checked_total++;
      if (mag !== item.magnitude) begin
        $display("%0t ns: magnitude expected %0d got %0d", $time, item.magnitude, mag);
        error_total++;
      end
      if (last !== item.frame_last) begin
        $display("%0t ns: frame last flag expected %0b got %0b", $time, item.frame_last, last);
        error_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      for (int i = 0; i < 2; i++) begin
        win_top[i] = '0;
        win_mid[i] = '0;
        win_bot[i] = '0;
      end
      expected_mags.delete();
    end else begin
      if (out_tvalid && out_tready) check_magnitude(out_tdata, out_tlast);
      if (cfg_we) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_wdata[11:0];
        else                              height_reg = cfg_wdata[15:0];
      end
      if (in_tvalid && in_tready) predict_pixel(in_tdata);
    end
    outstanding        <= expected_mags.size();
    mismatches         <= error_total;
    magnitudes_checked <= checked_total;
  end

endmodule

// ===== bench/tb_prewitt_edge_magnitude_unit.sv =====
// ----------------------------------------------------------------------------
// tb_prewitt_edge_magnitude_unit
// streams grayscale frames through the edge magnitude unit and checks results
// ----------------------------------------------------------------------------
// A few hand-built 3x3 frames hit the saturation boundary, the largest
// gradient and a negative gradient with an exact root. Random frames follow
// with changing sizes (register values below range included), several pixel
// patterns, bursty input and an unsteady receiver. One frame runs while the
// receiver holds off for a long stretch, one starts a long row at the widest
// width setting and is cut short, and one very tall frame has its height cut
// down in the middle. The checker module predicts and compares; this module
// only drives and reports.
// ----------------------------------------------------------------------------
module tb_prewitt_edge_magnitude_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pem_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int IDLE_SETTLE   = 24;
  localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int RANDOM_PIXELS = 800;
  localparam int WIDE_PIXELS   = 300;    // long partial row at the widest setting

  typedef enum int { PAT_NOISE, PAT_BINARY, PAT_RAMP, PAT_FLAT } pattern_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;     // [7:0] pixel
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;           // [7:0] magnitude
  logic             out_tlast;
  logic             cfg_we     = 1'b0;
  logic             cfg_index  = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata  = '0;

  int               outstanding;
  int               mismatches;
  int               magnitudes_checked;

  int               pixels_sent = 0;
  int               frames_sent = 0;
  int               reg_writes  = 0;
  int               burst_left  = 0;
  int               cycle_count = 0;
  bit               hold_off_req = 1'b0;
  logic [15:0]      width_raw  = 16'(WIDTH_RST);
  logic [15:0]      height_raw = HEIGHT_RST;

  // hand-built 3x3 frames, raster order
  //   sum of squares exactly 65536 (dx 256, dy 0): saturates
  //   dx 765, dy 0: largest square
  //   dx 0, dy -255: exact root 255 from a falling gradient
  logic [7:0] directed_px [27] = '{
    8'd0,   8'd0,   8'd86,  8'd0,   8'd55,  8'd85,  8'd0,   8'd1,   8'd85,
    8'd0,   8'd0,   8'd255, 8'd0,   8'd77,  8'd255, 8'd0,   8'd0,   8'd255,
    8'd255, 8'd255, 8'd255, 8'd180, 8'd9,   8'd180, 8'd170, 8'd170, 8'd170
  };

  prewitt_edge_magnitude_unit #(.MAX_WIDTH(MAX_WIDTH_DEF)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  prewitt_result_checker #(.MAX_WIDTH(MAX_WIDTH_DEF)) mag_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tlast          (out_tlast),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .outstanding        (outstanding),
    .mismatches         (mismatches),
    .magnitudes_checked (magnitudes_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // frame size in effect for a given register value
  function automatic int frame_width(input logic [15:0] raw);
    int w;
    w = raw[11:0];
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int frame_height(input logic [15:0] raw);
    return (raw < MIN_DIM) ? MIN_DIM : int'(raw);
  endfunction

  function automatic logic [7:0] pixel_at(input pattern_t pat, input int base,
                                          input int col, input int row);
    case (pat)
      PAT_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_RAMP:   return 8'(base + col * 3 + row * 5 + $urandom_range(0, 2));
      PAT_FLAT:   return 8'(base + $urandom_range(0, 3));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int new_burst();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 24);
  endfunction

  // offer one pixel and hold it until taken; bursts end in a random gap
  task automatic offer_pixel(input logic [7:0] pix);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    pixels_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = new_burst();
    end
  endtask

  // stop offering, wait for every predicted magnitude, then let border work finish
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_IMAGE_WIDTH) width_raw = value;
    else                        height_raw = value;
  endtask

  task automatic send_frame(input int w, input int h, input pattern_t pat);
    int base;
    base = $urandom_range(0, 255);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        offer_pixel(pixel_at(pat, base, c, r));
    frames_sent++;
  endtask

  // random frames; sizes change between frames only, with the block idle
  task automatic random_frames(input int pixel_budget);
    int start_px;
    int pick;
    int w_new;
    int h_new;
    start_px = pixels_sent;
    while (pixels_sent - start_px < pixel_budget) begin
      if ($urandom_range(0, 9) < 6) begin
        drain_results();
        pick = $urandom_range(0, 19);
        if (pick < 2)      w_new = $urandom_range(0, 2);      // clamped up to 3
        else if (pick < 5) w_new = $urandom_range(17, 120);
        else               w_new = $urandom_range(3, 16);
        pick = $urandom_range(0, 19);
        if (w_new > 16)    h_new = $urandom_range(3, 4);
        else if (pick < 2) h_new = $urandom_range(0, 2);      // raised to 3
        else if (pick < 5) h_new = $urandom_range(9, 20);
        else               h_new = $urandom_range(3, 8);
        // upper nibble of the width write is dropped by the block
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w_new)});
        if ($urandom_range(0, 3) != 0)
          write_reg(REG_IMAGE_HEIGHT, 16'(h_new));
      end
      send_frame(frame_width(width_raw), frame_height(height_raw),
                 pattern_t'($urandom_range(0, 3)));
    end
  endtask

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int seg_left;
    int phase;
    mode     = 0;
    seg_left = 0;
    phase    = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(16, 96);
        end
        seg_left--;
        phase++;
        case (mode)
          0: out_tready <= 1'b1;                               // no stalls
          1: out_tready <= ($urandom_range(0, 7) != 0);
          2: out_tready <= ($urandom_range(0, 2) == 0);
          default: out_tready <= ((phase % 6) < 2);            // fixed rhythm
        endcase
      end
    end
  end

  // watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d magnitudes still expected",
             cycle_count, outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int tall_rows;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = new_burst();

    // smallest frame for the hand-built windows
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    for (int i = 0; i < 27; i++) offer_pixel(directed_px[i]);
    frames_sent += 3;
    drain_results();

    random_frames(RANDOM_PIXELS / 2);

    // receiver stops for a long while mid-frame; the sender keeps offering
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 16'd24);
    write_reg(REG_IMAGE_HEIGHT, 16'd10);
    burst_left   = 1000;
    hold_off_req = 1'b1;
    send_frame(24, 10, PAT_NOISE);
    burst_left = new_burst();

    // widest setting: every bit of the width write set, clamped to the buffer
    // depth; a long first row is then cut short by a narrow width, so the
    // column counter wraps on the next pixel and two short rows end the frame
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    for (int i = 0; i < WIDE_PIXELS; i++) offer_pixel(8'(i * 3 + $urandom_range(0, 2)));
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 16'hF003);
    for (int i = 0; i < 7; i++) offer_pixel(8'($urandom_range(0, 255)));
    frames_sent++;

    // tallest frame, cut short: height lowered below the current row mid-row,
    // so the row counter wraps at the end of this row
    drain_results();
    write_reg(REG_IMAGE_WIDTH, 16'hF003);
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    tall_rows = 6;
    for (int i = 0; i < tall_rows * 3 + 1; i++) offer_pixel(8'($urandom_range(0, 255)));
    drain_results();
    write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(0, tall_rows)));
    for (int i = 0; i < 2; i++) offer_pixel(8'($urandom_range(0, 255)));
    frames_sent++;

    random_frames(RANDOM_PIXELS / 2);

    drain_results();
    $display("run covered %0d pixels in %0d frames, %0d magnitudes checked, %0d register writes",
             pixels_sent, frames_sent, magnitudes_checked, reg_writes);
    $display("sizes from 3x3 up to the clamped widest setting, clamped register values,");
    $display("rows cut short by register writes and a long output hold-off");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
